// ----- hw/rtl/dtp_pkg.sv -----
// Shared types, constants and command codes for the deadline timer pool.
// Used by dtp_cmp and deadline_timer_pool_unit; depends on nothing else.
`default_nettype none

package dtp_pkg;

    // Pool size and slot index width
    localparam int NUM_SLOTS = 10;
    localparam int SLOT_W    = 4;
    localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    // Tick counter: low part wraps at TICK_WRAP into the high part
    localparam int LOW_W  = 31;
    localparam int HIGH_W = 32;
    localparam logic [LOW_W-1:0] TICK_WRAP     = 31'd2147383600;
    localparam logic [LOW_W-1:0] TICK_WRAP_M1  = 31'd2147383599;
    localparam logic [32:0]      SUM_WRAP_X1   = 33'd2147383600;
    localparam logic [32:0]      SUM_WRAP_X2   = 33'd4294767200;
    localparam logic signed [33:0] REM_WRAP_X1 = 34'sd2147383600;
    localparam logic signed [33:0] REM_WRAP_X2 = 34'sd4294767200;
    localparam logic signed [33:0] REM_MAX     = 34'sd2147483647;
    localparam logic signed [33:0] REM_MIN     = -34'sd2147483648;

    // Command codes
    localparam logic [2:0] CMD_TICK  = 3'd0;
    localparam logic [2:0] CMD_ALLOC = 3'd1;
    localparam logic [2:0] CMD_FREE  = 3'd2;
    localparam logic [2:0] CMD_SET   = 3'd3;
    localparam logic [2:0] CMD_CHECK = 3'd4;
    localparam logic [2:0] CMD_READ  = 3'd5;

    // Status codes
    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FAIL = 1'b1;

    typedef logic [LOW_W-1:0]  t_low;
    typedef logic [HIGH_W-1:0] t_high;
    typedef logic [SLOT_W-1:0] t_slot;

    // Input item
    typedef struct packed {
        logic [2:0]  cmd;
        t_slot       slot;
        logic [30:0] delay_ticks;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic               status;
        t_slot              granted_slot;
        logic               expired;
        logic signed [31:0] remaining;
    } t_out_item;

endpackage

`default_nettype wire

// ----- hw/rtl/dtp_cmp.sv -----
// Deadline comparator: expiry test and saturated ticks remaining for one slot.
// Depends on dtp_pkg.
`default_nettype none

module dtp_cmp (
    input  dtp_pkg::t_low       i_now_low,
    input  dtp_pkg::t_high      i_now_high,
    input  dtp_pkg::t_low       i_dl_low,
    input  dtp_pkg::t_high      i_dl_high,
    output logic                o_expired,
    output logic signed [31:0]  o_remaining
);
    import dtp_pkg::*;

    logic signed [32:0] hd;
    logic signed [31:0] ld;
    logic signed [33:0] base;
    logic signed [33:0] sum;

    // Expiry: high part first, then low part
    assign o_expired = (i_now_high > i_dl_high) ||
                       ((i_now_high == i_dl_high) && (i_now_low >= i_dl_low));

    // Signed differences of both parts
    assign hd = $signed({1'b0, i_dl_high}) - $signed({1'b0, i_now_high});
    assign ld = $signed({1'b0, i_dl_low}) - $signed({1'b0, i_now_low});

    // High difference scaled by the wrap; only -2..2 matter, the rest saturates
    always_comb begin
        unique case (hd[2:0])
            3'b010:  base = REM_WRAP_X2;
            3'b001:  base = REM_WRAP_X1;
            3'b111:  base = -REM_WRAP_X1;
            3'b110:  base = -REM_WRAP_X2;
            default: base = '0;
        endcase
    end

    assign sum = base + 34'(ld);

    // Clamp to the 32-bit signed range
    always_comb begin
        priority if (hd >= 33'sd3) begin
            o_remaining = 32'(REM_MAX);
        end else if (hd <= -33'sd3) begin
            o_remaining = 32'(REM_MIN);
        end else if (sum > REM_MAX) begin
            o_remaining = 32'(REM_MAX);
        end else if (sum < REM_MIN) begin
            o_remaining = 32'(REM_MIN);
        end else begin
            o_remaining = sum[31:0];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/deadline_timer_pool_unit.sv -----
// Deadline timer pool: tick counter, slot claim bits and deadline registers.
// Depends on dtp_pkg and dtp_cmp.
//
// Usage:
//   Input channel i_in_valid / i_in_item / o_in_stall carries commands (tick,
//   allocate, release, set, check, read). Output channel o_out_valid /
//   o_out_item / i_out_stall returns exactly one result item per command.
//   An item is taken at an edge with valid high and stall low.
//   An accepted item sits in the input register, is executed against the
//   timer state when it leaves that register and is then offered from the
//   result register. Throughput is one item per cycle while the receiver
//   does not stall: each command is executed by the compare and add logic
//   between the input register and the result register.
//   Receiver stall: the result register holds its item; the input register
//   keeps one more item, after which o_in_stall rises.
//   i_cfg_we / i_cfg_wdata write pool_enabled; write it only while idle.
//   Reset (synchronous, i_rst_n low): counter, deadlines and claim bits are
//   cleared, the pool is disabled and both registers are emptied.
`default_nettype none

module deadline_timer_pool_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_wdata,
    input  logic                  i_in_valid,
    input  dtp_pkg::t_in_item     i_in_item,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    output dtp_pkg::t_out_item    o_out_item,
    input  logic                  i_out_stall
);
    import dtp_pkg::*;

    // Registers
    logic                r_pool_enabled;
    logic                r_in_valid;
    t_in_item            r_in;
    logic                r_out_valid;
    t_out_item           r_out;
    t_low                r_now_low;
    t_high               r_now_high;
    t_low                r_dl_low  [NUM_SLOTS];
    t_high               r_dl_high [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] r_claimed;

    // Next values
    t_out_item           n_out;
    t_low                n_now_low;
    t_high               n_now_high;
    logic [NUM_SLOTS-1:0] n_claimed;
    logic                n_set_we;
    t_low                n_set_low;
    t_high               n_set_high;

    logic                advance;
    logic                in_take;
    logic                slot_ok;
    logic [IDX_W-1:0]    rd_idx;
    logic [32:0]         set_sum;
    logic [32:0]         set_rem;
    logic [1:0]          set_q;
    logic                free_found;
    t_slot               free_slot;
    logic                cmp_expired;
    logic signed [31:0]  cmp_remaining;

    // Handshake: input register moves on when the result register is free
    assign advance     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !advance;
    assign in_take     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Slot decode; out-of-range slots read entry zero and are masked later
    assign slot_ok = (32'(r_in.slot) < 32'(NUM_SLOTS));
    assign rd_idx  = slot_ok ? r_in.slot[IDX_W-1:0] : '0;

    dtp_cmp u_cmp (
        .i_now_low   (r_now_low),
        .i_now_high  (r_now_high),
        .i_dl_low    (r_dl_low[rd_idx]),
        .i_dl_high   (r_dl_high[rd_idx]),
        .o_expired   (cmp_expired),
        .o_remaining (cmp_remaining)
    );

    // Lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (!free_found && !r_claimed[i]) begin
                free_found = 1'b1;
                free_slot  = SLOT_W'(i);
            end
        end
    end

    // Deadline for set: sum reduced modulo the wrap, quotient is 0..2
    assign set_sum = {2'b00, r_now_low} + {2'b00, r_in.delay_ticks};
    always_comb begin
        priority if (set_sum >= SUM_WRAP_X2) begin
            set_q   = 2'd2;
            set_rem = set_sum - SUM_WRAP_X2;
        end else if (set_sum >= SUM_WRAP_X1) begin
            set_q   = 2'd1;
            set_rem = set_sum - SUM_WRAP_X1;
        end else begin
            set_q   = 2'd0;
            set_rem = set_sum;
        end
    end
    assign n_set_low  = set_rem[LOW_W-1:0];
    assign n_set_high = r_now_high + HIGH_W'(set_q);

    // Command execution
    always_comb begin
        n_out      = '0;
        n_now_low  = r_now_low;
        n_now_high = r_now_high;
        n_claimed  = r_claimed;
        n_set_we   = 1'b0;
        unique case (r_in.cmd)
            CMD_TICK: begin
                if (r_now_low >= TICK_WRAP_M1) begin
                    n_now_low  = '0;
                    n_now_high = r_now_high + 1'b1;
                end else begin
                    n_now_low  = r_now_low + 1'b1;
                end
            end
            CMD_ALLOC: begin
                if (r_pool_enabled && free_found) begin
                    n_out.granted_slot = free_slot;
                    n_claimed[free_slot[IDX_W-1:0]] = 1'b1;
                end else begin
                    n_out.status = ST_FAIL;
                end
            end
            CMD_FREE: begin
                if (r_pool_enabled && slot_ok && r_claimed[rd_idx]) begin
                    n_claimed[rd_idx] = 1'b0;
                end else begin
                    n_out.status = ST_FAIL;
                end
            end
            CMD_SET: begin
                if (slot_ok) begin
                    n_set_we = 1'b1;
                end else begin
                    n_out.status = ST_FAIL;
                end
            end
            CMD_CHECK: begin
                if (slot_ok) begin
                    n_out.expired = cmp_expired;
                end else begin
                    n_out.status  = ST_FAIL;
                    n_out.expired = 1'b1;
                end
            end
            CMD_READ: begin
                if (slot_ok) begin
                    n_out.remaining = cmp_remaining;
                end else begin
                    n_out.status = ST_FAIL;
                end
            end
            default: begin
                n_out.status = ST_FAIL;
            end
        endcase
    end

    // Handshake registers and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_enabled <= 1'b0;
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_pool_enabled <= i_cfg_wdata;
            end
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_item;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    // Timer state: updated when an item executes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now_low  <= '0;
            r_now_high <= '0;
            r_claimed  <= '0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_dl_low[i]  <= '0;
                r_dl_high[i] <= '0;
            end
        end else if (advance) begin
            r_now_low  <= n_now_low;
            r_now_high <= n_now_high;
            r_claimed  <= n_claimed;
            if (n_set_we) begin
                r_dl_low[rd_idx]  <= n_set_low;
                r_dl_high[rd_idx] <= n_set_high;
            end
        end
    end

    // Checks
    a_low_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_now_low < TICK_WRAP)
        else $error("tick counter low part reached the wrap value");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid))
        else $error("input stalled with a free register");

    a_grant_claimed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in.cmd == CMD_ALLOC && n_out.status == ST_OK)
        |=> r_claimed[r_out.granted_slot[IDX_W-1:0]])
        else $error("granted slot not marked as claimed");

endmodule

`default_nettype wire
